// ===== rtl/core/hss_pkg.sv =====
// ----------------------------------------------------------------------------
// hss_pkg: shared definitions of the heightmap slope shading unit
// Types, constants and register codes used by the front, queue and back parts.
// ----------------------------------------------------------------------------
package hss_pkg;

	localparam int QDEPTH      = 8;
	localparam int QAW         = $clog2(QDEPTH);
	localparam int CNTW        = QAW + 1;
	localparam int FRONT_DEPTH = 4;
	localparam int SQ_STEPS    = 31;
	localparam int DIV_STEPS   = 17;

	localparam logic [15:0]        SIN60_Q    = 16'd56756;
	// Negated product of the light factor 75 and the sun vector component 37837.
	localparam logic signed [23:0] SHADE_GAIN = -24'sd2837775;
	localparam logic signed [23:0] FLAT_SHADE = 24'sd2837775;

	localparam logic [0:0] CFG_TRIANGLE_WIDTH = 1'd0;
	localparam logic [0:0] CFG_HEIGHT_FACTOR  = 1'd1;

	typedef struct packed {
		logic [7:0] triangle_width;
		logic [4:0] height_factor;
	} hss_cfg_t;

	typedef struct packed {
		logic [61:0] sum;
		logic [29:0] xmag;
		logic        xneg;
		logic [29:0] ymag;
		logic        yneg;
		logic [23:0] zmag;
		logic        twnz;
	} hss_item_t;

	typedef struct packed {
		logic            empty;
		logic [CNTW-1:0] count;
	} hss_qstat_t;

endpackage

// ===== rtl/core/heightmap_slope_shading_unit.sv =====
// ----------------------------------------------------------------------------
// heightmap_slope_shading_unit: brightness of one hexagonal heightmap vertex
// Throughput: one item per cycle while busy is low, set by the fully pipelined
// square root and dividers, one stage per root or quotient bit.
// Reset clears all control state; the registers return to width 64, factor 5.
// The receiver cannot stall, so busy stays low in operation.
// ----------------------------------------------------------------------------
module heightmap_slope_shading_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic signed [7:0] slope_left,
	input  logic signed [7:0] slope_right,
	input  logic signed [7:0] slope_top_left,
	input  logic signed [7:0] slope_top_right,
	input  logic signed [7:0] slope_bottom_left,
	input  logic signed [7:0] slope_bottom_right,
	output logic              done,
	output logic signed [7:0] brightness,
	input  logic              cfg_wen,
	input  logic [0:0]        cfg_index,
	input  logic [7:0]        cfg_data
);

	hss_pkg::hss_cfg_t   cfg_q;
	hss_pkg::hss_item_t  f_item, q_item;
	hss_pkg::hss_qstat_t q_stat;
	logic                f_push, q_valid, accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.triangle_width <= 8'd64;
			cfg_q.height_factor  <= 5'd5;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				hss_pkg::CFG_TRIANGLE_WIDTH: cfg_q.triangle_width <= cfg_data;
				hss_pkg::CFG_HEIGHT_FACTOR:  cfg_q.height_factor  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Hold off new beats only when the queue could not absorb the front stages.
	assign busy   = (q_stat.count >=
		hss_pkg::CNTW'(hss_pkg::QDEPTH - hss_pkg::FRONT_DEPTH));
	assign accept = start && !busy;

	hss_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.accept             (accept),
		.slope_left         (slope_left),
		.slope_right        (slope_right),
		.slope_top_left     (slope_top_left),
		.slope_top_right    (slope_top_right),
		.slope_bottom_left  (slope_bottom_left),
		.slope_bottom_right (slope_bottom_right),
		.cfg                (cfg_q),
		.push               (f_push),
		.item               (f_item)
	);

	hss_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  (f_item),
		.pop    (!q_stat.empty),
		.rdata  (q_item),
		.rvalid (q_valid),
		.stat   (q_stat)
	);

	hss_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (q_valid),
		.in_item    (q_item),
		.done       (done),
		.brightness (brightness)
	);

endmodule

// ===== rtl/core/hss_front.sv =====
// ----------------------------------------------------------------------------
// hss_front: normal vector front end
// Combines the six slopes into the normal and its squared length.
// ----------------------------------------------------------------------------
module hss_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic signed [7:0]   slope_left,
	input  logic signed [7:0]   slope_right,
	input  logic signed [7:0]   slope_top_left,
	input  logic signed [7:0]   slope_top_right,
	input  logic signed [7:0]   slope_bottom_left,
	input  logic signed [7:0]   slope_bottom_right,
	input  hss_pkg::hss_cfg_t   cfg,
	output logic                push,
	output hss_pkg::hss_item_t  item
);

	logic signed [10:0] a_c;
	logic signed [9:0]  b_c;

	logic              valid_s1, valid_s2, valid_s3, valid_s4;
	logic [9:0]        amag_s1;
	logic [8:0]        bmag_s1;
	logic              aneg_s1, bneg_s1;
	logic [14:0]       ha_s2;
	logic [13:0]       hb_s2;
	logic              aneg_s2, bneg_s2;
	logic [7:0]        tw_s2;
	logic [29:0]       ya_s3, hasq_s3, xmag_s3;
	logic [15:0]       twsq_s3;
	logic [23:0]       zmag_s3, zmag_s4;
	logic              aneg_s3, bneg_s3, twnz_s3;
	logic [59:0]       ysq_s4;
	logic [61:0]       part_s4;
	logic [29:0]       xmag_s4, ymag_s4;
	logic              aneg_s4, bneg_s4, twnz_s4;

	// x carries right and left fully and the diagonals at half weight, so x is
	// counted in halves here.
	assign a_c = ((11'(slope_right) - 11'(slope_left)) <<< 1)
		+ 11'(slope_top_right) - 11'(slope_top_left)
		+ 11'(slope_bottom_right) - 11'(slope_bottom_left);
	assign b_c = 10'(slope_bottom_left) + 10'(slope_bottom_right)
		- 10'(slope_top_left) - 10'(slope_top_right);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		amag_s1 <= a_c[10] ? 10'(-a_c) : 10'(a_c);
		bmag_s1 <= b_c[9] ? 9'(-b_c) : 9'(b_c);
		aneg_s1 <= a_c[10];
		bneg_s1 <= b_c[9];

		ha_s2   <= 15'(cfg.height_factor) * 15'(amag_s1);
		hb_s2   <= 14'(cfg.height_factor) * 14'(bmag_s1);
		aneg_s2 <= aneg_s1;
		bneg_s2 <= bneg_s1;
		tw_s2   <= cfg.triangle_width;

		ya_s3   <= 30'(hb_s2) * 30'(hss_pkg::SIN60_Q);
		hasq_s3 <= 30'(ha_s2) * 30'(ha_s2);
		twsq_s3 <= 16'(tw_s2) * 16'(tw_s2);
		xmag_s3 <= {ha_s2, 15'd0};
		zmag_s3 <= {tw_s2, 16'd0};
		aneg_s3 <= aneg_s2;
		bneg_s3 <= bneg_s2;
		twnz_s3 <= (tw_s2 != 8'd0);

		ysq_s4  <= 60'(ya_s3) * 60'(ya_s3);
		part_s4 <= 62'({hasq_s3, 30'd0}) + 62'({twsq_s3, 32'd0});
		xmag_s4 <= xmag_s3;
		ymag_s4 <= ya_s3;
		zmag_s4 <= zmag_s3;
		aneg_s4 <= aneg_s3;
		bneg_s4 <= bneg_s3;
		twnz_s4 <= twnz_s3;
	end

	assign push      = valid_s4;
	assign item.sum  = 62'(ysq_s4) + part_s4;
	assign item.xmag = xmag_s4;
	assign item.xneg = aneg_s4;
	assign item.ymag = ymag_s4;
	assign item.yneg = bneg_s4;
	assign item.zmag = zmag_s4;
	assign item.twnz = twnz_s4;

endmodule

// ===== rtl/core/hss_fifo.sv =====
// ----------------------------------------------------------------------------
// hss_fifo: queue between front and back
// Small register-file queue with a registered read port.
// ----------------------------------------------------------------------------
module hss_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  hss_pkg::hss_item_t  wdata,
	input  logic                pop,
	output hss_pkg::hss_item_t  rdata,
	output logic                rvalid,
	output hss_pkg::hss_qstat_t stat
);

	hss_pkg::hss_item_t             mem [hss_pkg::QDEPTH];
	logic [hss_pkg::QAW-1:0]        wr_ptr_q, rd_ptr_q;
	logic [hss_pkg::CNTW-1:0]       count_q;
	logic                           rvalid_q;
	hss_pkg::hss_item_t             rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q  <= count_q + hss_pkg::CNTW'(push) - hss_pkg::CNTW'(pop);
			rvalid_q <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wdata;
		if (pop)
			rdata_q <= mem[rd_ptr_q];
	end

	assign rdata      = rdata_q;
	assign rvalid     = rvalid_q;
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != hss_pkg::CNTW'(hss_pkg::QDEPTH)) || pop)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue read while empty");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a beat");
`endif

endmodule

// ===== rtl/core/hss_back.sv =====
// ----------------------------------------------------------------------------
// hss_back: normalization and shading back end
// Pipelined square root, three pipelined dividers and the shading arithmetic.
// ----------------------------------------------------------------------------
module hss_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  hss_pkg::hss_item_t in_item,
	output logic               done,
	output logic signed [7:0]  brightness
);

	typedef struct packed {
		hss_pkg::hss_item_t item;
		logic [33:0]        rem;
		logic [30:0]        q;
	} hss_sq_t;

	typedef struct packed {
		logic [30:0] len;
		logic [47:0] rx, ry, rz;
		logic [16:0] qx, qy, qz;
		logic        xneg, yneg, zero, twnz;
	} hss_dv_t;

	function automatic hss_sq_t sqrt_step(hss_sq_t s);
		hss_sq_t     o;
		logic [35:0] acc;
		logic [35:0] trial;
		o        = s;
		acc      = {s.rem, s.item.sum[61:60]};
		trial    = {3'd0, s.q, 2'b01};
		o.item.sum = {s.item.sum[59:0], 2'b00};
		if (acc >= trial) begin
			o.rem = 34'(acc - trial);
			o.q   = {s.q[29:0], 1'b1};
		end else begin
			o.rem = 34'(acc);
			o.q   = {s.q[29:0], 1'b0};
		end
		return o;
	endfunction

	function automatic hss_dv_t div_step(hss_dv_t s, logic [4:0] bitpos);
		hss_dv_t     o;
		logic [47:0] dv;
		o  = s;
		dv = 48'(s.len) << bitpos;
		if (s.rx >= dv) begin
			o.rx         = s.rx - dv;
			o.qx[bitpos] = 1'b1;
		end
		if (s.ry >= dv) begin
			o.ry         = s.ry - dv;
			o.qy[bitpos] = 1'b1;
		end
		if (s.rz >= dv) begin
			o.rz         = s.rz - dv;
			o.qz[bitpos] = 1'b1;
		end
		return o;
	endfunction

	hss_sq_t sq_s   [hss_pkg::SQ_STEPS+1];
	logic    sq_vld [hss_pkg::SQ_STEPS+1];
	hss_dv_t dv_s   [hss_pkg::DIV_STEPS+1];
	logic    dv_vld [hss_pkg::DIV_STEPS+1];

	logic signed [18:0] nx_c, ny_c, nz_c, m_c;
	logic signed [41:0] prod_s1;
	logic               twnz_s1, vld_s1, vld_s2;
	logic signed [25:0] shade_c;
	logic signed [27:0] diff_c, diff_s2, scaled_c, clamp_c;
	logic signed [27:0] round_c;
	logic               done_q;
	logic signed [7:0]  brightness_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= hss_pkg::SQ_STEPS; k++)
				sq_vld[k] <= 1'b0;
			for (int j = 0; j <= hss_pkg::DIV_STEPS; j++)
				dv_vld[j] <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			sq_vld[0] <= in_valid;
			for (int k = 0; k < hss_pkg::SQ_STEPS; k++)
				sq_vld[k+1] <= sq_vld[k];
			dv_vld[0] <= sq_vld[hss_pkg::SQ_STEPS];
			for (int j = 0; j < hss_pkg::DIV_STEPS; j++)
				dv_vld[j+1] <= dv_vld[j];
			vld_s1 <= dv_vld[hss_pkg::DIV_STEPS];
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		sq_s[0].item <= in_item;
		sq_s[0].rem  <= '0;
		sq_s[0].q    <= '0;
		for (int k = 0; k < hss_pkg::SQ_STEPS; k++)
			sq_s[k+1] <= sqrt_step(sq_s[k]);

		// The floor root is the common divisor; a zero root means a null normal.
		dv_s[0].len  <= sq_s[hss_pkg::SQ_STEPS].q;
		dv_s[0].rx   <= 48'({sq_s[hss_pkg::SQ_STEPS].item.xmag, 16'd0});
		dv_s[0].ry   <= 48'({sq_s[hss_pkg::SQ_STEPS].item.ymag, 16'd0});
		dv_s[0].rz   <= 48'({sq_s[hss_pkg::SQ_STEPS].item.zmag, 16'd0});
		dv_s[0].qx   <= '0;
		dv_s[0].qy   <= '0;
		dv_s[0].qz   <= '0;
		dv_s[0].xneg <= sq_s[hss_pkg::SQ_STEPS].item.xneg;
		dv_s[0].yneg <= sq_s[hss_pkg::SQ_STEPS].item.yneg;
		dv_s[0].zero <= (sq_s[hss_pkg::SQ_STEPS].q == '0);
		dv_s[0].twnz <= sq_s[hss_pkg::SQ_STEPS].item.twnz;
		for (int j = 0; j < hss_pkg::DIV_STEPS; j++)
			dv_s[j+1] <= div_step(dv_s[j], 5'(hss_pkg::DIV_STEPS - 1 - j));

		prod_s1      <= 42'(m_c) * 42'(hss_pkg::SHADE_GAIN);
		twnz_s1      <= dv_s[hss_pkg::DIV_STEPS].twnz;
		diff_s2      <= diff_c;
		brightness_q <= round_c[7:0];
	end

	always_comb begin
		nx_c = 19'(dv_s[hss_pkg::DIV_STEPS].qx);
		ny_c = 19'(dv_s[hss_pkg::DIV_STEPS].qy);
		nz_c = 19'(dv_s[hss_pkg::DIV_STEPS].qz);
		if (dv_s[hss_pkg::DIV_STEPS].xneg)
			nx_c = -nx_c;
		if (dv_s[hss_pkg::DIV_STEPS].yneg)
			ny_c = -ny_c;
		if (dv_s[hss_pkg::DIV_STEPS].zero) begin
			nx_c = '0;
			ny_c = '0;
			nz_c = '0;
		end
		m_c = nx_c - ny_c - nz_c;
	end

	// Divisions by 65536 truncate toward zero, so negative values are biased first.
	always_comb begin
		shade_c = 26'((prod_s1 + (prod_s1[41] ? 42'sd65535 : 42'sd0)) >>> 16);
		diff_c  = 28'(shade_c) - (twnz_s1 ? 28'(hss_pkg::FLAT_SHADE) : 28'sd0);

		if (diff_s2 > 28'sd0)
			scaled_c = (diff_s2 + (diff_s2 <<< 1)) >>> 1;
		else
			scaled_c = diff_s2;
		if (scaled_c < -28'sd8388608)
			clamp_c = -28'sd8388608;
		else if (scaled_c > 28'sd8323072)
			clamp_c = 28'sd8323072;
		else
			clamp_c = scaled_c;
		round_c = (clamp_c + (clamp_c[27] ? 28'sd65535 : 28'sd0)) >>> 16;
	end

	assign done       = done_q;
	assign brightness = brightness_q;

endmodule

// ===== tb/tb_heightmap_slope_shading_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_heightmap_slope_shading_unit: self-checking bench of the shading unit
// Drives vertex slopes in bursts under several register settings, predicts
// each brightness in fixed point and compares it with every result beat.
// ----------------------------------------------------------------------------
module tb_heightmap_slope_shading_unit;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 70;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic signed [7:0] slope_left, slope_right, slope_top_left, slope_top_right;
	logic signed [7:0] slope_bottom_left, slope_bottom_right;
	logic              done;
	logic signed [7:0] brightness;
	logic              cfg_wen;
	logic [0:0]        cfg_index;
	logic [7:0]        cfg_data;

	logic [7:0]  model_width;
	logic [4:0]  model_factor;
	logic signed [7:0] expected_brightness[$];
	int mismatches;
	int idle_cycles;

	heightmap_slope_shading_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.slope_left(slope_left), .slope_right(slope_right),
		.slope_top_left(slope_top_left), .slope_top_right(slope_top_right),
		.slope_bottom_left(slope_bottom_left), .slope_bottom_right(slope_bottom_right),
		.done(done), .brightness(brightness),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Sun term of one vertex in Q.16, before the flat-terrain offset.
	function automatic longint sun_term(input longint l, r, tl, tr, bl, br);
		longint hf, x, y, z, len, nx, ny, nz;
		longint unsigned ax, ay, az;
		hf = longint'(model_factor);
		x = hf * (r - l) * 65536 + hf * (tr - tl + br - bl) * 32768;
		y = hf * (bl + br - tl - tr) * longint'(hss_pkg::SIN60_Q);
		z = longint'(model_width) * 65536;
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		az = z;
		len = longint'(int_sqrt(ax * ax + ay * ay + az * az));
		nx = 0;
		ny = 0;
		nz = 0;
		if (len != 0) begin
			nx = (x * 65536) / len;
			ny = (y * 65536) / len;
			nz = (z * 65536) / len;
		end
		return (longint'(hss_pkg::SHADE_GAIN) * (nx - ny - nz)) / 65536;
	endfunction

	function automatic logic signed [7:0] predict_brightness(
			input logic signed [7:0] l, r, tl, tr, bl, br);
		longint d;
		d = sun_term(l, r, tl, tr, bl, br) - sun_term(0, 0, 0, 0, 0, 0);
		if (d > 0) d = (d * 3) / 2;
		if (d < -128 * 65536) d = -128 * 65536;
		else if (d > 127 * 65536) d = 127 * 65536;
		return 8'(d / 65536);
	endfunction

	// Drives one vertex from a clock edge and returns at the edge that takes it.
	task automatic send_vertex(input logic signed [7:0] l, r, tl, tr, bl, br);
		start              <= 1'b1;
		slope_left         <= l;
		slope_right        <= r;
		slope_top_left     <= tl;
		slope_top_right    <= tr;
		slope_bottom_left  <= bl;
		slope_bottom_right <= br;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_brightness.push_back(predict_brightness(l, r, tl, tr, bl, br));
	endtask

	task automatic pause(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (expected_brightness.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Registers only change once the pipeline has emptied.
	task automatic write_register(input logic [0:0] index, input logic [7:0] value);
		drain();
		cfg_wen   <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		if (index == hss_pkg::CFG_TRIANGLE_WIDTH) model_width = value;
		else model_factor = value[4:0];
	endtask

	function automatic logic signed [7:0] random_slope(input bit gentle);
		if (gentle) return 8'($signed($urandom_range(0, 16)) - 8);
		return 8'($urandom);
	endfunction

	task automatic test_extremes();
		logic signed [7:0] v;
		send_vertex(0, 0, 0, 0, 0, 0);
		send_vertex(127, 127, 127, 127, 127, 127);
		send_vertex(-128, -128, -128, -128, -128, -128);
		send_vertex(-128, 127, -128, 127, -128, 127);
		send_vertex(127, -128, 127, -128, 127, -128);
		send_vertex(0, 0, -128, -128, 127, 127);
		send_vertex(0, 0, 127, 127, -128, -128);
		for (int i = 0; i < 6; i++) begin
			v = (i % 2) ? 8'sd127 : -8'sd128;
			send_vertex(i == 0 ? v : 8'sd0, i == 1 ? v : 8'sd0, i == 2 ? v : 8'sd0,
				i == 3 ? v : 8'sd0, i == 4 ? v : 8'sd0, i == 5 ? v : 8'sd0);
		end
		send_vertex(1, -1, 2, -2, 3, -3);
		send_vertex(-1, 1, -2, 2, -3, 3);
		drain();
	endtask

	// Zero width with level terrain gives a zero-length normal.
	task automatic test_zero_length_normal();
		write_register(hss_pkg::CFG_TRIANGLE_WIDTH, 8'd0);
		send_vertex(0, 0, 0, 0, 0, 0);
		send_vertex(5, 5, 0, 0, 0, 0);
		send_vertex(-128, 127, 3, -3, 0, 0);
		write_register(hss_pkg::CFG_HEIGHT_FACTOR, 8'hE0);
		send_vertex(0, 0, 0, 0, 0, 0);
		send_vertex(127, -128, 127, -128, 127, -128);
		drain();
	endtask

	task automatic test_random(input int count);
		int burst;
		bit gentle;
		burst = $urandom_range(1, 30);
		for (int i = 0; i < count; i++) begin
			gentle = ($urandom_range(0, 3) != 0);
			send_vertex(random_slope(gentle), random_slope(gentle), random_slope(gentle),
				random_slope(gentle), random_slope(gentle), random_slope(gentle));
			burst--;
			if (burst == 0) begin
				if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 9));
				burst = $urandom_range(1, 30);
			end
		end
	endtask

	task automatic test_settings();
		logic [7:0] widths[6]  = '{8'd64, 8'd1, 8'd255, 8'd16, 8'd200, 8'd3};
		logic [7:0] factors[6] = '{8'd5, 8'd31, 8'd1, 8'd0, 8'd17, 8'd255};
		for (int k = 0; k < 6; k++) begin
			write_register(hss_pkg::CFG_TRIANGLE_WIDTH, widths[k]);
			write_register(hss_pkg::CFG_HEIGHT_FACTOR, factors[k]);
			test_random(145);
		end
		drain();
	endtask

	always @(posedge clk) begin
		if (done) begin
			if (expected_brightness.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected brightness beat %0d", brightness);
			end else begin
				if (brightness !== expected_brightness[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Brightness expected %0d, got %0d",
							expected_brightness[0], brightness);
				end
				void'(expected_brightness.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_wen) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		mismatches   = 0;
		idle_cycles  = 0;
		model_width  = 8'd64;
		model_factor = 5'd5;
		arst_n    = 1'b0;
		start     = 1'b0;
		cfg_wen   = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		slope_left = '0;
		slope_right = '0;
		slope_top_left = '0;
		slope_top_right = '0;
		slope_bottom_left = '0;
		slope_bottom_right = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_zero_length_normal();
		test_settings();
		if (mismatches == 0 && expected_brightness.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
